@@ design/c_comment_stripper_unit_defines.svh @@
// assertion macros shared by the comment stripper modules
`ifndef C_COMMENT_STRIPPER_UNIT_DEFINES_SVH
`define C_COMMENT_STRIPPER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define CSTRIP_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cstrip assertion failed");

`define CSTRIP_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("cstrip assertion failed");

`else

`define CSTRIP_ASSERT(name, clk, rst, prop)

`define CSTRIP_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

@@ design/cstrip_pkg.sv @@
// types and character constants for the comment stripper
package cstrip_pkg;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_NONE      = 8'h00;
   localparam logic [7:0] CH_ESC_DONE  = 8'h01;

   localparam logic [1:0] Q_NONE   = 2'd0;
   localparam logic [1:0] Q_SINGLE = 2'd1;
   localparam logic [1:0] Q_DOUBLE = 2'd2;

   localparam logic [1:0] C_NONE  = 2'd0;
   localparam logic [1:0] C_LINE  = 2'd1;
   localparam logic [1:0] C_BLOCK = 2'd2;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       no_byte;
      logic       is_last;
   } res_type;

   typedef struct packed {
      logic [1:0] count;
      res_type    res0;
      res_type    res1;
   } push_type;

endpackage

@@ design/cstrip_core.sv @@
// scanner state and per-byte result generation
`include "c_comment_stripper_unit_defines.svh"

module cstrip_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_accept,
   input  logic [7:0]           in_byte,
   input  logic                 in_end,
   output cstrip_pkg::push_type push
);

   logic [7:0] prev_ff, prev_in;
   logic [1:0] quote_ff, quote_in;
   logic [1:0] comment_ff, comment_in;
   logic       held_valid_ff, held_valid_in;
   logic [7:0] held_byte_ff;

   logic       emit, drop, pair;
   logic [7:0] next_prev;
   logic [1:0] q, cm;
   logic       held_out, hold_new, byte_out;

   always_comb begin
      emit      = 1'b0;
      drop      = 1'b0;
      pair      = 1'b0;
      next_prev = in_byte;
      q         = quote_ff;
      cm        = comment_ff;
      if (prev_ff == cstrip_pkg::CH_NONE) begin
         emit = 1'b1;
      end else begin
         if (cm == cstrip_pkg::C_NONE) begin
            if (in_byte == cstrip_pkg::CH_BACKSLASH && prev_ff == cstrip_pkg::CH_BACKSLASH) begin
               pair      = 1'b1;
               emit      = 1'b1;
               next_prev = cstrip_pkg::CH_ESC_DONE;
            end else if (prev_ff != cstrip_pkg::CH_BACKSLASH) begin
               if (in_byte == cstrip_pkg::CH_SQUOTE) begin
                  if (q == cstrip_pkg::Q_NONE) q = cstrip_pkg::Q_SINGLE;
                  else if (q == cstrip_pkg::Q_SINGLE) q = cstrip_pkg::Q_NONE;
               end else if (in_byte == cstrip_pkg::CH_DQUOTE) begin
                  if (q == cstrip_pkg::Q_NONE) q = cstrip_pkg::Q_DOUBLE;
                  else if (q == cstrip_pkg::Q_DOUBLE) q = cstrip_pkg::Q_NONE;
               end
            end
         end
         if (!pair) begin
            if (prev_ff == cstrip_pkg::CH_SLASH && q == cstrip_pkg::Q_NONE &&
                cm == cstrip_pkg::C_NONE &&
                (in_byte == cstrip_pkg::CH_SLASH || in_byte == cstrip_pkg::CH_STAR)) begin
               cm   = (in_byte == cstrip_pkg::CH_SLASH) ? cstrip_pkg::C_LINE
                                                        : cstrip_pkg::C_BLOCK;
               drop = 1'b1;
            end else if (prev_ff == cstrip_pkg::CH_STAR && q == cstrip_pkg::Q_NONE &&
                         in_byte == cstrip_pkg::CH_SLASH && cm == cstrip_pkg::C_BLOCK) begin
               cm = cstrip_pkg::C_NONE;
            end else begin
               if (prev_ff == cstrip_pkg::CH_NEWLINE && cm == cstrip_pkg::C_LINE)
                  cm = cstrip_pkg::C_NONE;
               emit = (cm == cstrip_pkg::C_NONE);
            end
         end
      end
   end

   assign held_out = held_valid_ff & ~drop;
   assign hold_new = emit & (in_byte == cstrip_pkg::CH_SLASH) & ~in_end;
   assign byte_out = emit & ~hold_new;

   always_comb begin
      push = '0;
      if (held_out) begin
         push.res0.out_byte = held_byte_ff;
      end else if (byte_out) begin
         push.res0.out_byte = in_byte;
      end
      push.res0.no_byte  = ~held_out & ~byte_out;
      push.res0.is_last  = in_end & ~(held_out & byte_out);
      push.res1.out_byte = in_byte;
      push.res1.no_byte  = 1'b0;
      push.res1.is_last  = in_end;
      if (in_accept) begin
         if (held_out && byte_out) push.count = 2'd2;
         else if (held_out || byte_out || in_end) push.count = 2'd1;
         else push.count = 2'd0;
      end
   end

   always_comb begin
      prev_in       = prev_ff;
      quote_in      = quote_ff;
      comment_in    = comment_ff;
      held_valid_in = held_valid_ff;
      if (in_accept) begin
         if (in_end) begin
            prev_in       = cstrip_pkg::CH_NONE;
            quote_in      = cstrip_pkg::Q_NONE;
            comment_in    = cstrip_pkg::C_NONE;
            held_valid_in = 1'b0;
         end else begin
            prev_in       = next_prev;
            quote_in      = q;
            comment_in    = cm;
            held_valid_in = hold_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff       <= cstrip_pkg::CH_NONE;
         quote_ff      <= cstrip_pkg::Q_NONE;
         comment_ff    <= cstrip_pkg::C_NONE;
         held_valid_ff <= 1'b0;
      end else begin
         prev_ff       <= prev_in;
         quote_ff      <= quote_in;
         comment_ff    <= comment_in;
         held_valid_ff <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept && hold_new) held_byte_ff <= in_byte;
   end

   `CSTRIP_ASSERT(a_held_is_slash, clock, reset, held_valid_ff |-> held_byte_ff == cstrip_pkg::CH_SLASH)
   `CSTRIP_ASSERT(a_end_clears, clock, reset, in_accept && in_end |=> prev_ff == cstrip_pkg::CH_NONE && !held_valid_ff && comment_ff == cstrip_pkg::C_NONE)
   `CSTRIP_ASSERT(a_end_gives_result, clock, reset, in_accept && in_end |-> push.count != 2'd0)

endmodule

@@ design/cstrip_outq.sv @@
// result queue taking up to two results per cycle
`include "c_comment_stripper_unit_defines.svh"

module cstrip_outq #(
   parameter int Depth = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cstrip_pkg::push_type push,
   output logic                 space_ok,
   output logic                 out_valid,
   input  logic                 out_ready,
   output cstrip_pkg::res_type  out_res
);

   localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CW = $clog2(Depth + 1);

   cstrip_pkg::res_type entries_ff [Depth];
   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] tail_next1, tail_next2;
   logic          pop;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      logic [PW-1:0] r;
      if (p == PW'(Depth - 1)) r = '0;
      else r = p + PW'(1);
      return r;
   endfunction

   assign tail_next1 = ptr_inc(tail_ff);
   assign tail_next2 = ptr_inc(tail_next1);
   assign out_valid  = (count_ff != '0);
   assign out_res    = entries_ff[head_ff];
   assign pop        = out_valid & out_ready;
   assign space_ok   = (count_ff <= CW'(Depth - 2));

   always_comb begin
      head_in  = pop ? ptr_inc(head_ff) : head_ff;
      count_in = count_ff + CW'(push.count) - CW'(pop);
      case (push.count)
         2'd1:    tail_in = tail_next1;
         2'd2:    tail_in = tail_next2;
         default: tail_in = tail_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entries_ff[tail_ff] <= push.res0;
      if (push.count == 2'd2) entries_ff[tail_next1] <= push.res1;
   end

   `CSTRIP_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(Depth))
   `CSTRIP_ASSERT(a_push_has_room, clock, reset, push.count != 2'd0 |-> count_ff <= CW'(Depth - 2) || push.count == 2'd1 && count_ff <= CW'(Depth - 1))
   `CSTRIP_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> count_ff == '0)

endmodule

@@ design/c_comment_stripper_unit.sv @@
// comment stripper top level: input scanner feeding a small result queue
// results of an accepted byte are offered on rsp from the next cycle, behind queued results
// a '/' is held back until the following byte decides whether it opens a comment
// throughput: one byte per cycle, set by the scanner state update; input stalls only
// when the queue has fewer than two free entries
// reset: synchronous, clears scanner state and empties the queue
module c_comment_stripper_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte[7:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte[7:0]
   output logic        rsp_tuser,   // no_byte[0]
   output logic        rsp_tlast
);

   cstrip_pkg::push_type push;
   cstrip_pkg::res_type  head_res;
   logic                 space_ok;
   logic                 req_xfer;

   assign req_tready = space_ok;
   assign req_xfer   = req_tvalid & space_ok;

   cstrip_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_xfer),
      .in_byte   (req_tdata),
      .in_end    (req_tlast),
      .push      (push)
   );

   cstrip_outq #(
      .Depth (QUEUE_DEPTH)
   ) u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (head_res)
   );

   assign rsp_tdata = head_res.out_byte;
   assign rsp_tuser = head_res.no_byte;
   assign rsp_tlast = head_res.is_last;

endmodule
